// ===== sv/vector_draw_command_stream_parser_defines.svh =====
// Assertion macros for the drawing-command stream parser.
// Included by the RTL files that carry concurrent checks; no dependencies.
`ifndef VECTOR_DRAW_COMMAND_STREAM_PARSER_DEFINES_SVH
`define VECTOR_DRAW_COMMAND_STREAM_PARSER_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define VDCSP_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define VDCSP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define VDCSP_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`define VDCSP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== sv/vdcsp_pkg.sv =====
// Shared types and constants of the drawing-command stream parser.
// No dependencies; imported by every module of the block.
package vdcsp_pkg;

  typedef enum logic [2:0] {
    KIND_IMAGE     = 3'd0,
    KIND_SEQUENCE  = 3'd1,
    KIND_FRAME     = 3'd2,
    KIND_COMMAND   = 3'd3,
    KIND_POINT     = 3'd4,
    KIND_BAD_MAGIC = 3'd5
  } rec_kind_e;

  typedef struct packed {
    rec_kind_e          kind;
    logic [7:0]         version_or_type;
    logic signed [15:0] x_or_width;
    logic signed [15:0] y_or_height;
    logic [15:0]        item_count;
    logic [7:0]         cmd_flags;
    logic signed [7:0]  stroke_colour;
    logic [7:0]         stroke_thickness;
    logic signed [7:0]  fill_colour;
    logic [15:0]        aux_word;
    logic               final_res;
  } rec_t;

  // One parse step's outcome handed to the result register.
  typedef struct packed {
    logic valid;
    rec_t rec;
  } res_t;

  localparam logic [7:0] MAGIC_PREFIX [3] = '{8'h50, 8'h44, 8'h43};
  localparam logic [7:0] MAGIC_IMAGE = 8'h49;
  localparam logic [7:0] MAGIC_SEQ   = 8'h53;

  localparam logic [3:0] MAGIC_LAST     = 4'd3;
  localparam logic [3:0] SIZE_LAST      = 4'd3;
  localparam logic [3:0] HDR_WIDTH_POS  = 4'd3;
  localparam logic [3:0] HDR_HEIGHT_POS = 4'd5;
  localparam logic [3:0] IMAGE_HDR_LAST = 4'd7;
  localparam logic [3:0] SEQ_HDR_LAST   = 4'd9;
  localparam logic [3:0] CMD_HDR_LAST   = 4'd8;
  localparam logic [3:0] WORD_LO_POS    = 4'd1;
  localparam logic [3:0] PAIR_LAST      = 4'd3;

endpackage

// ===== sv/vector_draw_command_stream_parser.sv =====
// Drawing-command stream parser: input register, parse core, result register.
// Depends on vdcsp_pkg, vdcsp_parse_core and vdcsp_out_reg.
//
// Feed the file one byte per transfer, starting at the 4-byte magic ("PDCI"
// image or "PDCS" sequence; any other magic gives one bad-magic record with
// final_res set). The 4-byte size is skipped, multi-byte values are
// little-endian, and each header, frame, command and point comes out as one
// record on the transfer after the byte that completes it. The last record of
// the file carries final_res; every byte after it is dropped until reset.
// Throughput is one byte per cycle while the result side is not stalled: each
// byte is held in the input register, is parsed in a single pass, and its
// record lands in the result register, so a record becomes visible once its
// last byte has passed through both registers, and can then transfer out.
// Backpressure on the result side stalls parsing only once the result
// register is full and not being drained.
module vector_draw_command_stream_parser
  import vdcsp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         in_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         record_kind_o,
  output logic [7:0]         version_or_type_o,
  output logic signed [15:0] x_or_width_o,
  output logic signed [15:0] y_or_height_o,
  output logic [15:0]        item_count_o,
  output logic [7:0]         cmd_flags_o,
  output logic signed [7:0]  stroke_colour_o,
  output logic [7:0]         stroke_thickness_o,
  output logic signed [7:0]  fill_colour_o,
  output logic [15:0]        aux_word_o,
  output logic               final_res_o
);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       out_free;
  logic       step;
  res_t       res;
  rec_t       rec;

  // Parse the held byte whenever the result register can take its outcome.
  assign step       = in_valid_q && out_free;
  // Accept a new byte when the input register is empty or drains this cycle.
  assign in_ready_o = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // Capture the payload only on an input transfer.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= in_byte_i;
    end
  end

  vdcsp_parse_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte_q),
    .res_o  (res)
  );

  vdcsp_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .out_ready_i (out_ready_i),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .rec_o       (rec)
  );

  // Break the held record out onto the individual field ports.
  assign record_kind_o      = rec.kind;
  assign version_or_type_o  = rec.version_or_type;
  assign x_or_width_o       = rec.x_or_width;
  assign y_or_height_o      = rec.y_or_height;
  assign item_count_o       = rec.item_count;
  assign cmd_flags_o        = rec.cmd_flags;
  assign stroke_colour_o    = rec.stroke_colour;
  assign stroke_thickness_o = rec.stroke_thickness;
  assign fill_colour_o      = rec.fill_colour;
  assign aux_word_o         = rec.aux_word;
  assign final_res_o        = rec.final_res;

endmodule

// ===== sv/vdcsp_out_reg.sv =====
// Result register of the drawing-command stream parser.
// Depends on vdcsp_pkg for the record types.
module vdcsp_out_reg
  import vdcsp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  res_t res_i,
  input  logic out_ready_i,
  output logic free_o,
  output logic out_valid_o,
  output rec_t rec_o
);

  logic valid_q;
  rec_t rec_q;

  // Slot frees up when empty or when the held record transfers this cycle.
  assign free_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= res_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && res_i.valid) begin
      rec_q <= res_i.rec;
    end
  end

  assign out_valid_o = valid_q;
  assign rec_o       = rec_q;

endmodule

// ===== sv/vdcsp_parse_core.sv =====
// Parse state and single-step record builder of the drawing-command parser.
// Depends on vdcsp_pkg and the assertion macros header.
`include "vector_draw_command_stream_parser_defines.svh"

module vdcsp_parse_core
  import vdcsp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  output res_t       res_o
);

  localparam logic [2:0] PH_MAGIC = 3'd0;
  localparam logic [2:0] PH_SIZE  = 3'd1;
  localparam logic [2:0] PH_HDR   = 3'd2;
  localparam logic [2:0] PH_FRAME = 3'd3;
  localparam logic [2:0] PH_CMD   = 3'd4;
  localparam logic [2:0] PH_POINT = 3'd5;
  localparam logic [2:0] PH_DONE  = 3'd6;

  logic [2:0]  phase_q, phase_d;
  logic [3:0]  pos_q, pos_d;
  logic [7:0]  prev_q, prev_d;
  logic        bad_q, bad_d;
  logic        seq_q, seq_d;
  logic [15:0] frames_q, frames_d;
  logic [15:0] cmds_q, cmds_d;
  logic [15:0] pts_q, pts_d;

  logic [7:0]  ver_q, ver_d;
  logic [15:0] wid_q, wid_d;
  logic [15:0] hgt_q, hgt_d;
  logic [15:0] hf3_q, hf3_d;
  logic [15:0] held_x_q, held_x_d;
  logic [7:0]  cmd_q [8];
  logic        cmd_we;

  logic [15:0] val;
  logic        adv;
  res_t        res;

  assign val = {byte_i, prev_q};

  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    prev_d   = prev_q;
    bad_d    = bad_q;
    seq_d    = seq_q;
    frames_d = frames_q;
    cmds_d   = cmds_q;
    pts_d    = pts_q;
    ver_d    = ver_q;
    wid_d    = wid_q;
    hgt_d    = hgt_q;
    hf3_d    = hf3_q;
    held_x_d = held_x_q;
    cmd_we   = 1'b0;
    adv      = 1'b0;
    res      = '0;

    if (step_i) begin
      case (phase_q)
        PH_MAGIC: begin
          if (pos_q < MAGIC_LAST) begin
            if (byte_i != MAGIC_PREFIX[pos_q[1:0]]) begin
              bad_d = 1'b1;
            end
            pos_d = pos_q + 4'd1;
          end else if (!bad_q && (byte_i == MAGIC_IMAGE || byte_i == MAGIC_SEQ)) begin
            seq_d   = (byte_i == MAGIC_SEQ);
            phase_d = PH_SIZE;
            pos_d   = '0;
            prev_d  = '0;
          end else begin
            phase_d            = PH_DONE;
            res.valid          = 1'b1;
            res.rec.kind       = KIND_BAD_MAGIC;
            res.rec.final_res  = 1'b1;
          end
        end
        PH_SIZE: begin
          pos_d = pos_q + 4'd1;
          if (pos_q == SIZE_LAST) begin
            phase_d = PH_HDR;
            pos_d   = '0;
          end
        end
        PH_HDR: begin
          if (pos_q == '0) ver_d = byte_i;
          if (pos_q == HDR_WIDTH_POS) wid_d = val;
          if (pos_q == HDR_HEIGHT_POS) hgt_d = val;
          if (pos_q == IMAGE_HDR_LAST && !seq_q) begin
            cmds_d                  = val;
            frames_d                = '0;
            pts_d                   = '0;
            res.valid               = 1'b1;
            res.rec.kind            = KIND_IMAGE;
            res.rec.item_count      = val;
            res.rec.version_or_type = ver_q;
            res.rec.x_or_width      = wid_q;
            res.rec.y_or_height     = hgt_q;
            adv                     = 1'b1;
          end else if (pos_q == IMAGE_HDR_LAST) begin
            hf3_d  = val;
            prev_d = byte_i;
            pos_d  = pos_q + 4'd1;
          end else if (pos_q == SEQ_HDR_LAST) begin
            frames_d                = val;
            cmds_d                  = '0;
            pts_d                   = '0;
            res.valid               = 1'b1;
            res.rec.kind            = KIND_SEQUENCE;
            res.rec.item_count      = val;
            res.rec.aux_word        = hf3_q;
            res.rec.version_or_type = ver_q;
            res.rec.x_or_width      = wid_q;
            res.rec.y_or_height     = hgt_q;
            adv                     = 1'b1;
          end else begin
            prev_d = byte_i;
            pos_d  = pos_q + 4'd1;
          end
        end
        PH_FRAME: begin
          if (pos_q == WORD_LO_POS) hf3_d = val;
          if (pos_q < PAIR_LAST) begin
            prev_d = byte_i;
            pos_d  = pos_q + 4'd1;
          end else begin
            frames_d           = frames_q - 16'd1;
            cmds_d             = val;
            res.valid          = 1'b1;
            res.rec.kind       = KIND_FRAME;
            res.rec.item_count = val;
            res.rec.aux_word   = hf3_q;
            adv                = 1'b1;
          end
        end
        PH_CMD: begin
          if (pos_q < CMD_HDR_LAST) begin
            cmd_we = 1'b1;
            pos_d  = pos_q + 4'd1;
          end else begin
            cmds_d                   = cmds_q - 16'd1;
            pts_d                    = {byte_i, cmd_q[7]};
            res.valid                = 1'b1;
            res.rec.kind             = KIND_COMMAND;
            res.rec.version_or_type  = cmd_q[0];
            res.rec.item_count       = {byte_i, cmd_q[7]};
            res.rec.cmd_flags        = cmd_q[1];
            res.rec.stroke_colour    = cmd_q[2];
            res.rec.stroke_thickness = cmd_q[3];
            res.rec.fill_colour      = cmd_q[4];
            res.rec.aux_word         = {cmd_q[6], cmd_q[5]};
            adv                      = 1'b1;
          end
        end
        PH_POINT: begin
          if (pos_q == WORD_LO_POS) held_x_d = val;
          if (pos_q < PAIR_LAST) begin
            prev_d = byte_i;
            pos_d  = pos_q + 4'd1;
          end else begin
            pts_d               = pts_q - 16'd1;
            res.valid           = 1'b1;
            res.rec.kind        = KIND_POINT;
            res.rec.x_or_width  = held_x_q;
            res.rec.y_or_height = val;
            adv                 = 1'b1;
          end
        end
        default: begin
          // Done: drop every further byte.
        end
      endcase

      // Record complete: pick the innermost list that still has entries.
      if (adv) begin
        pos_d  = '0;
        prev_d = '0;
        if (pts_d != '0) begin
          phase_d = PH_POINT;
        end else if (cmds_d != '0) begin
          phase_d = PH_CMD;
        end else if (frames_d != '0) begin
          phase_d = PH_FRAME;
        end else begin
          phase_d = PH_DONE;
        end
        res.rec.final_res = (phase_d == PH_DONE);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_MAGIC;
      pos_q    <= '0;
      prev_q   <= '0;
      bad_q    <= 1'b0;
      seq_q    <= 1'b0;
      frames_q <= '0;
      cmds_q   <= '0;
      pts_q    <= '0;
    end else begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      prev_q   <= prev_d;
      bad_q    <= bad_d;
      seq_q    <= seq_d;
      frames_q <= frames_d;
      cmds_q   <= cmds_d;
      pts_q    <= pts_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ver_q    <= ver_d;
    wid_q    <= wid_d;
    hgt_q    <= hgt_d;
    hf3_q    <= hf3_d;
    held_x_q <= held_x_d;
    if (cmd_we) begin
      cmd_q[pos_q[2:0]] <= byte_i;
    end
  end

  assign res_o = res;

  `VDCSP_ASSERT_IMPLY(done_silent_a, clk_i, rst_ni, phase_q == PH_DONE, !res.valid, "record after end of file")
  `VDCSP_ASSERT_NEXT(final_ends_a, clk_i, rst_ni, res.valid && res.rec.final_res, phase_q == PH_DONE, "parser still active after final record")
  `VDCSP_ASSERT_IMPLY(bad_final_a, clk_i, rst_ni, res.valid && res.rec.kind == KIND_BAD_MAGIC, res.rec.final_res, "bad magic record not final")
  `VDCSP_ASSERT_NEXT(idle_hold_a, clk_i, rst_ni, !step_i, phase_q == $past(phase_q) && pos_q == $past(pos_q), "parse state moved without a byte")

endmodule
